// File: src/pbp_pkg.sv
// Package for the popcount bucket placement block: shared widths, item codes,
// the back-end state type and the command word passed through the queue.
// No dependencies.
`default_nettype none

package pbp_pkg;

    localparam int MASK_W = 16;
    localparam int SLOT_W = 16;
    localparam int CNT_W  = 5;   // popcount of a 16-bit mask: 0..16
    localparam int CFG_W  = 5;
    localparam int POS_W  = 17;

    localparam logic [CFG_W-1:0] BIT_COUNT_RST = 5'd4;

    // Item kind codes, shared by the input kind and the result kind
    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_PLACE   = 1'b1;

    typedef enum logic [1:0] {
        ST_PLACE,
        ST_PASCAL,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic              restart;
        logic              error;
        logic [CNT_W-1:0]  bucket;
        logic [MASK_W-1:0] mask;
    } cmd_t;

endpackage

`default_nettype wire

// File: src/pbp_front.sv
// Front end: accepts items, counts the mask bits and flags out-of-range masks.
// Depends on pbp_pkg.
`default_nettype none

module pbp_front
    import pbp_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [MASK_W-1:0] mask_value,
    input  wire logic [IDX_W-1:0]  n,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    logic [2:0]         nib_cnt [4];
    logic [CNT_W-1:0]   pop_cnt;
    logic [MASK_W:0]    low_ones;
    logic               high_bits;

    // Count per nibble, then add the four counts
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            nib_cnt[i] = 3'({2'b00, mask_value[4*i]})   + 3'({2'b00, mask_value[4*i+1]})
                       + 3'({2'b00, mask_value[4*i+2]}) + 3'({2'b00, mask_value[4*i+3]});
        end
        pop_cnt = CNT_W'({2'b00, nib_cnt[0]}) + CNT_W'({2'b00, nib_cnt[1]})
                + CNT_W'({2'b00, nib_cnt[2]}) + CNT_W'({2'b00, nib_cnt[3]});
    end

    assign low_ones  = ((MASK_W+1)'(1) << n) - (MASK_W+1)'(1);
    assign high_bits = |(mask_value & ~low_ones[MASK_W-1:0]);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.restart = (kind == KIND_RESTART);
        q_cmd.error   = (kind == KIND_PLACE) && high_bits;
        q_cmd.bucket  = pop_cnt;
        q_cmd.mask    = mask_value;
    end

endmodule

`default_nettype wire

// File: src/pbp_queue.sv
// Two-entry command queue between the front and the back end.
// Depends on pbp_pkg.
`default_nettype none

module pbp_queue
    import pbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/pbp_back.sv
// Back end: holds the per-bucket next positions, runs the Pascal-row restart
// sequence and drives the output register. Depends on pbp_pkg.
`default_nettype none

module pbp_back
    import pbp_pkg::*;
#(
    parameter int DEPTH = 17,
    parameter int IDX_W = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  n,
    input  wire logic              q_valid,
    input  cmd_t                   q_cmd,
    output logic                   q_pop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   result_kind,
    output logic [SLOT_W-1:0]      slot,
    output logic [MASK_W-1:0]      value,
    output logic                   error,
    output logic                   last
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   step_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [SLOT_W-1:0]  acc_reg;
    logic [SLOT_W-1:0]  acc_next;
    logic [SLOT_W-1:0]  row_reg [DEPTH];
    logic [SLOT_W-1:0]  row_next [DEPTH];
    logic [POS_W-1:0]   pos_reg [DEPTH];
    logic [POS_W-1:0]   pos_next [DEPTH];

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_kind_reg;
    logic               out_kind_next;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [SLOT_W-1:0]  out_slot_next;
    logic [MASK_W-1:0]  out_value_reg;
    logic [MASK_W-1:0]  out_value_next;
    logic               out_error_reg;
    logic               out_error_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_load;

    logic               out_free;
    logic [IDX_W-1:0]   bkt;
    logic [POS_W-1:0]   cur_pos;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_PLACE) && q_valid && out_free;
    assign bkt      = q_cmd.bucket[IDX_W-1:0];
    assign cur_pos  = pos_reg[bkt];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_PLACE:
            begin
                if (q_pop && q_cmd.restart)
                begin
                    state_next = ST_PASCAL;
                end
            end
            ST_PASCAL:
            begin
                if (step_reg == n)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (idx_reg == n))
                begin
                    state_next = ST_PLACE;
                end
            end
            default:
            begin
                state_next = ST_PLACE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        step_next      = step_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_PLACE:
            begin
                if (q_pop && q_cmd.restart)
                begin
                    // Seed row 0 of the triangle, drop all old positions
                    for (int j = 0; j < DEPTH; j++)
                    begin
                        row_next[j] = '0;
                        pos_next[j] = '0;
                    end
                    row_next[0] = SLOT_W'(1);
                    step_next   = '0;
                    idx_next    = '0;
                    acc_next    = '0;
                end
                else if (q_pop)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_PLACE;
                    out_value_next = q_cmd.mask;
                    out_error_next = q_cmd.error;
                    out_last_next  = 1'b1;
                    if (q_cmd.error)
                    begin
                        out_slot_next = '0;
                    end
                    else
                    begin
                        out_slot_next = cur_pos[SLOT_W-1:0];
                        pos_next[bkt] = cur_pos + POS_W'(1);
                    end
                end
            end
            ST_PASCAL:
            begin
                if (step_reg != n)
                begin
                    // One Pascal step: every entry but entry 0 adds its left neighbor
                    for (int j = 1; j < DEPTH; j++)
                    begin
                        row_next[j] = row_reg[j] + row_reg[j-1];
                    end
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = KIND_RESTART;
                    out_slot_next  = SLOT_W'(idx_reg);
                    out_value_next = acc_reg;
                    out_error_next = 1'b0;
                    out_last_next  = (idx_reg == n);
                    pos_next[idx_reg] = {1'b0, acc_reg};
                    acc_next = acc_reg + row_reg[idx_reg];
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PLACE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < DEPTH; j++)
            begin
                pos_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        row_reg       <= row_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign slot        = out_slot_reg;
    assign value       = out_value_reg;
    assign error       = out_error_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

// File: src/popcount_bucket_placement.sv
// Top level of the popcount bucket placement block: configuration register,
// front end, command queue and back end. Depends on pbp_pkg and its submodules.
//
// Usage
//   Input channel (in_valid/in_ready, kind, mask_value): kind 0 is a restart,
//   kind 1 places one mask. Output channel (out_valid/out_ready) carries
//   result_kind, slot, value, error and last. The cfg channel
//   (cfg_valid/cfg_ready, cfg_data) writes bit_count n; cfg_ready is always
//   high and values above MAX_BITS act as MAX_BITS.
// Timing
//   A place item passes through a queue entry, then the output register.
//   Places stream at one item per cycle while out_ready is high and no
//   restart runs; the single read-modify-write of the bucket position
//   registers in the back end sets that rate. A restart occupies the back
//   end: it seeds the row, runs the Pascal steps (one parallel add across
//   the row per cycle), then emits n+1 bucket start offsets, last one marked.
//   The front keeps accepting into a two-entry queue while the back is busy.
// Reset
//   Reset sets n to 4, clears every bucket position and empties the queue
//   and the output register.
// Stall
//   When out_ready is low the output register holds its item, the back end
//   stops bar Pascal steps, the queue fills, in_ready drops; nothing is lost.
`default_nettype none

module popcount_bucket_placement
    import pbp_pkg::*;
#(
    parameter int MAX_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire logic [MASK_W-1:0] mask_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   result_kind,
    output logic [SLOT_W-1:0]      slot,
    output logic [MASK_W-1:0]      value,
    output logic                   error,
    output logic                   last
);

    localparam int DEPTH = MAX_BITS + 1;
    localparam int IDX_W = $clog2(DEPTH);

    logic [CFG_W-1:0] bit_count_reg;
    logic [CFG_W-1:0] bit_count_next;
    logic [IDX_W-1:0] n_eff;

    logic             q_full;
    logic             q_push;
    cmd_t             q_push_cmd;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_head;

    // Configuration: take every write, clamp on use
    assign cfg_ready      = 1'b1;
    assign bit_count_next = (cfg_valid && cfg_ready) ? cfg_data : bit_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= BIT_COUNT_RST;
        end
        else
        begin
            bit_count_reg <= bit_count_next;
        end
    end

    assign n_eff = (32'(bit_count_reg) > MAX_BITS) ? IDX_W'(MAX_BITS)
                                                    : IDX_W'(bit_count_reg);

    pbp_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .mask_value (mask_value),
        .n          (n_eff),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_push_cmd)
    );

    pbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    pbp_back #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .n           (n_eff),
        .q_valid     (q_valid),
        .q_cmd       (q_head),
        .q_pop       (q_pop),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .result_kind (result_kind),
        .slot        (slot),
        .value       (value),
        .error       (error),
        .last        (last)
    );

endmodule

`default_nettype wire

// File: src/pbp_checker.sv
// Port-level checker for popcount_bucket_placement, bound to the top level.
// Depends on pbp_pkg.
`default_nettype none

module pbp_checker
    import pbp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              kind,
    input wire logic [MASK_W-1:0] mask_value,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              result_kind,
    input wire logic [SLOT_W-1:0] slot,
    input wire logic [MASK_W-1:0] value,
    input wire logic              error,
    input wire logic              last
);

    // Hold a waiting input item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(mask_value))
        else $error("waiting input item changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(value)
                                    && $stable(result_kind) && $stable(last))
        else $error("stalled result changed");

    // Index-table entries with no gap between them have slots that rise by one
    a_table_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (result_kind == KIND_RESTART) && !last
        |=> !out_valid || ((result_kind == KIND_RESTART)
                           && (slot == $past(slot) + SLOT_W'(1))))
        else $error("index table out of sequence");

    // Flagged masks get slot zero and close their item
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> (result_kind == KIND_PLACE) && (slot == '0) && last)
        else $error("malformed error result");

    // A placement is always the only result of its item
    a_place_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == KIND_PLACE) |-> last)
        else $error("placement without last");

endmodule

bind popcount_bucket_placement pbp_checker u_pbp_checker (.*);

`default_nettype wire
